FILE: hw/rtl/chained_hash_table_defines.svh
// Assertion macros for the chained hash table RTL.
// Included by the top level; clk_i and rst_ni must be in scope where used.
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CHT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("chained_hash_table assertion failed");
`define CHT_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("chained_hash_table reset assertion failed");
`else
`define CHT_ASSERT(lbl, prop)
`define CHT_ASSERT_NR(lbl, prop)
`endif
`endif

FILE: hw/rtl/cht_pkg.sv
// Shared constants for the chained hash table.
// Used by cht_mod and chained_hash_table; depends on nothing.
package cht_pkg;

  localparam int KEY_W    = 31;
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 3;
  localparam int BUCKET_W = 4;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] STAT_REMOVED   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd4;

  // The modulo unit consumes the key one byte per cycle.
  localparam int MOD_STEP_W = 8;
  localparam int MOD_STEPS  = 4;
  localparam int MOD_IN_W   = MOD_STEP_W * MOD_STEPS;

endpackage

FILE: hw/rtl/cht_mod.sv
// Multi-cycle unit that reduces a key modulo the bucket count.
// Depends on cht_pkg for the key width and the step size.
module cht_mod #(
  parameter int NUM_BUCKETS = 13
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [cht_pkg::KEY_W-1:0]       key_i,
  output logic                            done_o,
  output logic [$clog2(NUM_BUCKETS)-1:0]  rem_o
);

  localparam int RemW = $clog2(NUM_BUCKETS);
  localparam int TW   = RemW + cht_pkg::MOD_STEP_W;
  localparam int CntW = $clog2(cht_pkg::MOD_STEPS);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [cht_pkg::MOD_IN_W-1:0]  key_q, key_d;
  logic [RemW-1:0]               rem_q, rem_d;
  logic [TW-1:0]                 acc;

  // Each step folds in one byte; the partial value stays below 256 times
  // the bucket count, so eight compare-subtract stages bring it back in range.
  always_comb begin
    logic [TW-1:0] sub;
    acc = {rem_q, key_q[cht_pkg::MOD_IN_W-1 -: cht_pkg::MOD_STEP_W]};
    for (int k = cht_pkg::MOD_STEP_W - 1; k >= 0; k--) begin
      sub = TW'(NUM_BUCKETS) << k;
      if (acc >= sub) begin
        acc = acc - sub;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    key_d  = key_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      key_d  = cht_pkg::MOD_IN_W'(key_i);
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = acc[RemW-1:0];
      key_d = key_q << cht_pkg::MOD_STEP_W;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(cht_pkg::MOD_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: hw/rtl/chained_hash_table.sv
// Top level of the chained hash table: request handshake, bucket row memory
// and the read-modify-write datapath. Depends on cht_pkg, cht_mod and the
// assertion macros in chained_hash_table_defines.svh.
//
// Each word in carries an action (insert, search, remove) and a 31-bit key;
// each gives exactly one word out with a status and the low four bits of the
// bucket index. One request is handled at a time, in order: acceptance, the
// modulo unit (one key byte per cycle), the bucket row read and the parallel
// compare and write-back, which waits while an unaccepted result word is held.
// Every bucket is one wide memory row with its fill count. After reset a
// clearing pass over all NUM_BUCKETS rows zeroes the counts, and no request is
// accepted until it ends. A finished result waits in an output register while
// the next request is accepted.
`include "chained_hash_table_defines.svh"

module chained_hash_table #(
  parameter int NUM_BUCKETS = 13,
  parameter int CHAIN_DEPTH = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [cht_pkg::ACT_W-1:0]      action_i,
  input  logic [cht_pkg::KEY_W-1:0]      key_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [cht_pkg::STAT_W-1:0]     status_o,
  output logic [cht_pkg::BUCKET_W-1:0]   bucket_o
);

  localparam int RowW = $clog2(NUM_BUCKETS);
  localparam int CntW = $clog2(CHAIN_DEPTH + 1);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_EXEC = 2'd3;

  typedef struct packed {
    logic [CntW-1:0]                          cnt;
    logic [CHAIN_DEPTH-1:0][cht_pkg::KEY_W-1:0] keys;
  } row_t;

  logic [1:0]                   state_q, state_d;
  logic [RowW-1:0]              clr_q, clr_d;
  logic [RowW-1:0]              row_q, row_d;
  logic [cht_pkg::ACT_W-1:0]    act_q, act_d;
  logic [cht_pkg::KEY_W-1:0]    key_q, key_d;
  logic                         out_valid_q, out_valid_d;
  logic [cht_pkg::STAT_W-1:0]   status_q, status_d;
  logic [cht_pkg::BUCKET_W-1:0] bucket_q, bucket_d;

  row_t                         row_mem [NUM_BUCKETS];
  row_t                         rd_q;
  row_t                         new_row;
  logic [cht_pkg::STAT_W-1:0]   new_status;

  logic                         mod_start;
  logic                         mod_done;
  logic [RowW-1:0]              mod_rem;
  logic                         wr_go;
  logic                         mem_we;
  logic [RowW-1:0]              mem_waddr;
  row_t                         mem_wdata;

  logic [CHAIN_DEPTH-1:0]       hit;
  logic [CHAIN_DEPTH-1:0]       shift_from;
  logic                         found;
  logic                         full;

  assign in_ready_o = (state_q == ST_IDLE);
  assign mod_start  = in_valid_i && in_ready_o;
  assign wr_go      = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  cht_mod #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .key_i  (key_i),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  // Slots below the fill count are compared in parallel. From the first hit
  // upward every slot takes its upper neighbor, which removes that entry.
  always_comb begin
    for (int i = 0; i < CHAIN_DEPTH; i++) begin
      hit[i] = (rd_q.keys[i] == key_q) && (CntW'(i) < rd_q.cnt);
    end
    found      = |hit;
    shift_from = hit | ~(hit - CHAIN_DEPTH'(1));
    full       = (rd_q.cnt == CntW'(CHAIN_DEPTH));
  end

  always_comb begin
    new_row    = rd_q;
    new_status = cht_pkg::STAT_NOT_FOUND;
    case (act_q)
      cht_pkg::ACT_INSERT: begin
        if (full) begin
          new_status = cht_pkg::STAT_FULL;
        end else begin
          for (int i = 0; i < CHAIN_DEPTH; i++) begin
            if (CntW'(i) == rd_q.cnt) begin
              new_row.keys[i] = key_q;
            end
          end
          new_row.cnt = rd_q.cnt + 1'b1;
          new_status  = cht_pkg::STAT_INSERTED;
        end
      end
      cht_pkg::ACT_REMOVE: begin
        if (found) begin
          for (int i = 0; i < CHAIN_DEPTH - 1; i++) begin
            if (shift_from[i]) begin
              new_row.keys[i] = rd_q.keys[i+1];
            end
          end
          new_row.cnt = rd_q.cnt - 1'b1;
          new_status  = cht_pkg::STAT_REMOVED;
        end
      end
      default: begin
        new_status = found ? cht_pkg::STAT_FOUND : cht_pkg::STAT_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    row_d       = row_q;
    act_d       = act_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    bucket_d    = bucket_q;
    case (state_q)
      ST_CLR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == RowW'(NUM_BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_i;
          key_d   = key_i;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          row_d   = mod_rem;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (wr_go) begin
          out_valid_d = 1'b1;
          status_d    = new_status;
          bucket_d    = cht_pkg::BUCKET_W'(row_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    act_q    <= act_d;
    key_q    <= key_d;
    status_q <= status_d;
    bucket_q <= bucket_d;
  end

  assign mem_we    = (state_q == ST_CLR) || wr_go;
  assign mem_waddr = (state_q == ST_CLR) ? clr_q : row_q;
  assign mem_wdata = (state_q == ST_CLR) ? row_t'('0) : new_row;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    if (mod_done) begin
      rd_q <= row_mem[mod_rem];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign bucket_o    = bucket_q;

  `CHT_ASSERT(a_clr_blocks_input, (state_q == ST_CLR) |-> !in_ready_o)
  `CHT_ASSERT(a_mod_done_in_mod, mod_done |-> (state_q == ST_MOD))
  `CHT_ASSERT(a_writeback_gives_word, wr_go |=> out_valid_o)
  `CHT_ASSERT(a_count_bounded, (state_q == ST_EXEC) |-> (rd_q.cnt <= CntW'(CHAIN_DEPTH)))
  `CHT_ASSERT_NR(a_reset_clears, !rst_ni |=> (!rst_ni || ((state_q == ST_CLR) && !out_valid_o)))

endmodule

FILE: verif/chained_hash_table_tb.sv
`timescale 1ns / 100ps
// Testbench for chained_hash_table. It predicts each result word with its own
// bucket row model and checks it. Depends on cht_pkg and the chained_hash_table RTL.
module chained_hash_table_tb;

  localparam int NUM_BUCKETS = 13;
  localparam int CHAIN_DEPTH = 8;
  localparam logic [cht_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [cht_pkg::STAT_W-1:0]   status;
    logic [cht_pkg::BUCKET_W-1:0] bucket;
  } lookup_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [cht_pkg::ACT_W-1:0]    action_i;
  logic [cht_pkg::KEY_W-1:0]    key_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [cht_pkg::STAT_W-1:0]   status_o;
  logic [cht_pkg::BUCKET_W-1:0] bucket_o;

  logic [cht_pkg::KEY_W-1:0] row_keys [NUM_BUCKETS][CHAIN_DEPTH];
  int                        row_fill [NUM_BUCKETS];
  lookup_result_t            pending_results[$];
  logic [cht_pkg::KEY_W-1:0] stored_keys[$];
  int                        mismatches;
  bit                        steady;

  chained_hash_table #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .CHAIN_DEPTH(CHAIN_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .key_i      (key_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .bucket_o   (bucket_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic lookup_result_t apply_request(input logic [cht_pkg::ACT_W-1:0] act,
                                                   input logic [cht_pkg::KEY_W-1:0] key);
    lookup_result_t res;
    int row;
    int hit;
    row = key % NUM_BUCKETS;
    hit = -1;
    res.bucket = row[cht_pkg::BUCKET_W-1:0];
    for (int i = 0; i < row_fill[row]; i++) begin
      if (hit < 0 && row_keys[row][i] == key) begin
        hit = i;
      end
    end
    if (act == cht_pkg::ACT_INSERT) begin
      if (row_fill[row] >= CHAIN_DEPTH) begin
        res.status = cht_pkg::STAT_FULL;
      end else begin
        row_keys[row][row_fill[row]] = key;
        row_fill[row]++;
        res.status = cht_pkg::STAT_INSERTED;
      end
    end else if (act == cht_pkg::ACT_REMOVE) begin
      if (hit < 0) begin
        res.status = cht_pkg::STAT_NOT_FOUND;
      end else begin
        for (int i = hit; i + 1 < row_fill[row]; i++) begin
          row_keys[row][i] = row_keys[row][i+1];
        end
        row_fill[row]--;
        res.status = cht_pkg::STAT_REMOVED;
      end
    end else begin
      res.status = (hit < 0) ? cht_pkg::STAT_NOT_FOUND : cht_pkg::STAT_FOUND;
    end
    return res;
  endfunction

  task automatic send_word(input logic [cht_pkg::ACT_W-1:0] act,
                           input logic [cht_pkg::KEY_W-1:0] key);
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_i      <= key;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_request(act, key));
  endtask

  task automatic maybe_gap();
    if (!steady && $urandom_range(0, 99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() > 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 15);
  end

  always @(posedge clk_i) begin
    lookup_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word status=%0d bucket=%0d",
                                  status_o, bucket_o));
      end else begin
        exp_res = pending_results.pop_front();
        if (status_o !== exp_res.status) begin
          report_mismatch($sformatf("status expected %0d got %0d",
                                    exp_res.status, status_o));
        end
        if (bucket_o !== exp_res.bucket) begin
          report_mismatch($sformatf("bucket expected %0d got %0d",
                                    exp_res.bucket, bucket_o));
        end
      end
    end
  end

  task automatic test_edge_keys();
    logic [cht_pkg::KEY_W-1:0] top_key;
    top_key = {cht_pkg::KEY_W{1'b1}};
    send_word(cht_pkg::ACT_INSERT, '0);
    send_word(cht_pkg::ACT_SEARCH, '0);
    send_word(ACT_UNUSED, '0);
    send_word(cht_pkg::ACT_REMOVE, '0);
    send_word(cht_pkg::ACT_REMOVE, '0);
    send_word(cht_pkg::ACT_SEARCH, top_key);
    send_word(cht_pkg::ACT_INSERT, top_key);
    send_word(ACT_UNUSED, top_key);
    send_word(cht_pkg::ACT_REMOVE, top_key);
  endtask

  task automatic test_full_row();
    for (int i = 0; i <= CHAIN_DEPTH; i++) begin
      send_word(cht_pkg::ACT_INSERT, cht_pkg::KEY_W'(5 + NUM_BUCKETS * i));
    end
    send_word(cht_pkg::ACT_REMOVE, cht_pkg::KEY_W'(5 + NUM_BUCKETS * 3));
    send_word(cht_pkg::ACT_SEARCH, cht_pkg::KEY_W'(5 + NUM_BUCKETS * 3));
    send_word(cht_pkg::ACT_INSERT, cht_pkg::KEY_W'(5));
    send_word(cht_pkg::ACT_REMOVE, cht_pkg::KEY_W'(5));
    send_word(cht_pkg::ACT_SEARCH, cht_pkg::KEY_W'(5));
  endtask

  task automatic test_random_mix(input int count);
    logic [cht_pkg::ACT_W-1:0] act;
    logic [cht_pkg::KEY_W-1:0] key;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) act = cht_pkg::ACT_INSERT;
      else if (pick < 65) act = cht_pkg::ACT_SEARCH;
      else if (pick < 95) act = cht_pkg::ACT_REMOVE;
      else act = ACT_UNUSED;
      pick = $urandom_range(0, 99);
      if (stored_keys.size() > 0 && pick < 55) begin
        key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      end else if (pick < 78) begin
        key = cht_pkg::KEY_W'($urandom_range(0, 200));
      end else begin
        key = cht_pkg::KEY_W'($urandom);
      end
      if (act == cht_pkg::ACT_INSERT) begin
        stored_keys.push_back(key);
        if (stored_keys.size() > 48) stored_keys.delete(0);
      end
      maybe_gap();
      send_word(act, key);
    end
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_ready_i = 1'b0;
    action_i    = cht_pkg::ACT_INSERT;
    key_i       = '0;
    mismatches  = 0;
    steady      = 1'b0;
    foreach (row_fill[i]) row_fill[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_edge_keys();
    drain_results();
    test_full_row();
    drain_results();
    test_random_mix(700);
    drain_results();
    steady = 1'b1;
    test_random_mix(300);
    steady = 1'b0;
    test_random_mix(450);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (pending_results.size() > 0) begin
      report_mismatch($sformatf("%0d result words never arrived", pending_results.size()));
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
